[sv/dia_pkg.sv]
// ----------------------------------------------------------------------------
// dia_pkg
// Shared types and codes for the direction input auto-repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package dia_pkg;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_BUTTON  = 2'd1,
      CMD_STICK   = 2'd2,
      CMD_TRIGGER = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_UP     = 3'd1,
      ACT_DOWN   = 3'd2,
      ACT_LEFT   = 3'd3,
      ACT_RIGHT  = 3'd4,
      ACT_HOLD   = 3'd5,
      ACT_ROTATE = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      REG_PRESS_DZ    = 3'd0,
      REG_RELEASE_DZ  = 3'd1,
      REG_TRIGGER_LVL = 3'd2,
      REG_MENU_FIRST  = 3'd3,
      REG_MENU_PERIOD = 3'd4,
      REG_GAME_FIRST  = 3'd5,
      REG_GAME_PERIOD = 3'd6,
      REG_POLICY_GAME = 3'd7
   } reg_index_type;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic [2:0] SRC_KEY   = 3'b001;
   localparam logic [2:0] SRC_DPAD  = 3'b010;
   localparam logic [2:0] SRC_STICK = 3'b100;

   localparam logic [1:0] STK_CENTER = 2'd0;
   localparam logic [1:0] STK_NEG    = 2'd1;
   localparam logic [1:0] STK_POS    = 2'd2;

   localparam int CSR_DATA_W = 16;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        now_ms;
      logic [1:0]         dir_code;
      logic               from_dpad;
      logic               pressed;
      logic               axis_sel;
      logic signed [15:0] axis_value;
   } req_word_type;

endpackage

`default_nettype wire

[sv/dia_req_if.sv]
// ----------------------------------------------------------------------------
// dia_req_if
// Event channel: valid/ready handshake with one input event word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dia_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [31:0]        now_ms;
   logic [1:0]         dir_code;
   logic               from_dpad;
   logic               pressed;
   logic               axis_sel;
   logic signed [15:0] axis_value;

   modport source (
      output valid, command, now_ms, dir_code, from_dpad, pressed, axis_sel, axis_value,
      input  ready
   );
   modport sink (
      input  valid, command, now_ms, dir_code, from_dpad, pressed, axis_sel, axis_value,
      output ready
   );
endinterface

`default_nettype wire

[sv/dia_rsp_if.sv]
// ----------------------------------------------------------------------------
// dia_rsp_if
// Result channel: valid/ready handshake with one action word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dia_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action_code;

   modport source (
      output valid, action_code,
      input  ready
   );
   modport sink (
      input  valid, action_code,
      output ready
   );
endinterface

`default_nettype wire

[sv/direction_input_autorepeat.sv]
// ----------------------------------------------------------------------------
// direction_input_autorepeat
// Direction auto-repeat with per-source held masks, stick hysteresis and
// trigger edge detection.
//
// Usage:
//   req_ch carries one timestamped event word per handshake (tick, button
//   change, stick sample or trigger sample). rsp_ch returns exactly one
//   action word per event, in order.
//   csr_we/csr_index/csr_wdata write the deadzones, trigger level, repeat
//   timing and policy; write them only while no event is in flight.
//   An event is held in the event register and its action word in the action
//   register. Throughput: one event per cycle while rsp_ch.ready is high;
//   the event register and the action register form a two-entry pipeline,
//   so a stalled action still lets one more event in. The limit is the
//   single update of the held masks and repeat timer per cycle.
//   Reset (synchronous, active high) empties both registers, clears held
//   masks, stick and trigger states, repeat stamp, and reloads the
//   registers with their defaults.
//   When rsp_ch.ready is low the action word holds and req_ch.ready drops
//   once the event register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module direction_input_autorepeat #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   dia_req_if.sink                            req_ch,
   dia_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [dia_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [14:0] press_dz_ff;
   logic [14:0] release_dz_ff;
   logic [14:0] trig_lvl_ff;
   logic [15:0] menu_first_ff;
   logic [15:0] menu_period_ff;
   logic [15:0] game_first_ff;
   logic [15:0] game_period_ff;
   logic        policy_game_ff;

   logic                  in_valid_ff;
   dia_pkg::req_word_type in_ff;
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_action_ff;

   logic [3:0][2:0]       held_ff, held_in;
   logic [1:0]            stx_ff, stx_in, sty_ff, sty_in;
   logic                  tl_on_ff, tl_on_in, tr_on_ff, tr_on_in;
   logic [TIME_BITS-1:0]  stamp_ff, stamp_in;
   logic                  seen_ff, seen_in;
   logic [2:0]            act_in;

   logic                  advance;
   logic [TIME_BITS-1:0]  now_t;
   logic [TIME_BITS-1:0]  elapsed;
   logic [15:0]           delay_sel;
   logic [1:0]            tick_dir;
   logic                  any_held;
   logic                  fire;

   logic signed [16:0]    v_s, pz_s, npz_s, rz_s, nrz_s, tl_s;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.action_code = rsp_action_ff;

   assign now_t   = TIME_BITS'(in_ff.now_ms);
   assign elapsed = now_t - stamp_ff;

   assign v_s   = {in_ff.axis_value[15], in_ff.axis_value};
   assign pz_s  = {2'b00, press_dz_ff};
   assign npz_s = -pz_s;
   assign rz_s  = {2'b00, release_dz_ff};
   assign nrz_s = -rz_s;
   assign tl_s  = {2'b00, trig_lvl_ff};

   always_comb begin
      any_held = (held_ff[0] != 3'b000) || (held_ff[1] != 3'b000) ||
                 (held_ff[2] != 3'b000) || (held_ff[3] != 3'b000);
      if (held_ff[dia_pkg::DIR_DOWN] != 3'b000) begin
         tick_dir = dia_pkg::DIR_DOWN;
      end else if (held_ff[dia_pkg::DIR_LEFT] != 3'b000) begin
         tick_dir = dia_pkg::DIR_LEFT;
      end else if (held_ff[dia_pkg::DIR_RIGHT] != 3'b000) begin
         tick_dir = dia_pkg::DIR_RIGHT;
      end else begin
         tick_dir = dia_pkg::DIR_UP;
      end
      if (policy_game_ff) begin
         delay_sel = seen_ff ? game_period_ff : game_first_ff;
      end else begin
         delay_sel = seen_ff ? menu_period_ff : menu_first_ff;
      end
      fire = any_held && !(policy_game_ff && (tick_dir == dia_pkg::DIR_UP)) &&
             (elapsed >= TIME_BITS'(delay_sel));
   end

   always_comb begin
      logic [2:0] src_bit;
      logic [2:0] before_m;
      logic [2:0] after_m;
      logic [1:0] st_old;
      logic [1:0] st_nxt;
      logic [1:0] neg_dir;
      logic [1:0] pos_dir;
      logic [1:0] new_dir;
      logic       trig_down;
      logic       trig_on;

      held_in  = held_ff;
      stx_in   = stx_ff;
      sty_in   = sty_ff;
      tl_on_in = tl_on_ff;
      tr_on_in = tr_on_ff;
      stamp_in = stamp_ff;
      seen_in  = seen_ff;
      act_in   = dia_pkg::ACT_NONE;

      src_bit   = in_ff.from_dpad ? dia_pkg::SRC_DPAD : dia_pkg::SRC_KEY;
      before_m  = 3'b000;
      after_m   = 3'b000;
      neg_dir   = in_ff.axis_sel ? dia_pkg::DIR_UP : dia_pkg::DIR_LEFT;
      pos_dir   = in_ff.axis_sel ? dia_pkg::DIR_DOWN : dia_pkg::DIR_RIGHT;
      st_old    = in_ff.axis_sel ? sty_ff : stx_ff;
      if ((st_old != dia_pkg::STK_NEG) && (st_old != dia_pkg::STK_POS)) begin
         st_old = dia_pkg::STK_CENTER;
      end
      st_nxt    = st_old;
      new_dir   = pos_dir;
      trig_down = v_s > tl_s;
      trig_on   = in_ff.axis_sel ? tr_on_ff : tl_on_ff;

      case (dia_pkg::cmd_type'(in_ff.command))
         dia_pkg::CMD_TICK: begin
            if (fire) begin
               stamp_in = now_t;
               seen_in  = 1'b1;
               act_in   = {1'b0, tick_dir} + 3'd1;
            end
         end
         dia_pkg::CMD_BUTTON: begin
            before_m = held_ff[in_ff.dir_code];
            after_m  = in_ff.pressed ? (before_m | src_bit) : (before_m & ~src_bit);
            held_in[in_ff.dir_code] = after_m;
            if ((before_m == 3'b000) && (after_m != 3'b000)) begin
               stamp_in = now_t;
               seen_in  = 1'b0;
               act_in   = {1'b0, in_ff.dir_code} + 3'd1;
            end
         end
         dia_pkg::CMD_STICK: begin
            if (st_old == dia_pkg::STK_CENTER) begin
               if (v_s <= npz_s) begin
                  st_nxt = dia_pkg::STK_NEG;
               end else if (v_s >= pz_s) begin
                  st_nxt = dia_pkg::STK_POS;
               end
            end else begin
               if ((v_s > nrz_s) && (v_s < rz_s)) begin
                  st_nxt = dia_pkg::STK_CENTER;
               end else if ((st_old == dia_pkg::STK_NEG) && (v_s >= pz_s)) begin
                  st_nxt = dia_pkg::STK_POS;
               end else if ((st_old == dia_pkg::STK_POS) && (v_s <= npz_s)) begin
                  st_nxt = dia_pkg::STK_NEG;
               end
            end
            if (st_nxt != st_old) begin
               if (st_old == dia_pkg::STK_NEG) begin
                  held_in[neg_dir] = held_in[neg_dir] & ~dia_pkg::SRC_STICK;
               end else if (st_old == dia_pkg::STK_POS) begin
                  held_in[pos_dir] = held_in[pos_dir] & ~dia_pkg::SRC_STICK;
               end
               if (in_ff.axis_sel) begin
                  sty_in = st_nxt;
               end else begin
                  stx_in = st_nxt;
               end
               if (st_nxt != dia_pkg::STK_CENTER) begin
                  new_dir  = (st_nxt == dia_pkg::STK_NEG) ? neg_dir : pos_dir;
                  before_m = held_in[new_dir];
                  held_in[new_dir] = before_m | dia_pkg::SRC_STICK;
                  if (before_m == 3'b000) begin
                     stamp_in = now_t;
                     seen_in  = 1'b0;
                     act_in   = {1'b0, new_dir} + 3'd1;
                  end
               end
            end
         end
         dia_pkg::CMD_TRIGGER: begin
            if (trig_down != trig_on) begin
               if (in_ff.axis_sel) begin
                  tr_on_in = trig_down;
               end else begin
                  tl_on_in = trig_down;
               end
               if (trig_down) begin
                  act_in = in_ff.axis_sel ? dia_pkg::ACT_ROTATE : dia_pkg::ACT_HOLD;
               end
            end
         end
         default: begin
            act_in = dia_pkg::ACT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_dz_ff    <= 15'd16000;
         release_dz_ff  <= 15'd8000;
         trig_lvl_ff    <= 15'd8000;
         menu_first_ff  <= 16'd300;
         menu_period_ff <= 16'd100;
         game_first_ff  <= 16'd170;
         game_period_ff <= 16'd50;
         policy_game_ff <= 1'b0;
      end else if (csr_we) begin
         case (dia_pkg::reg_index_type'(csr_index))
            dia_pkg::REG_PRESS_DZ:    press_dz_ff    <= csr_wdata[14:0];
            dia_pkg::REG_RELEASE_DZ:  release_dz_ff  <= csr_wdata[14:0];
            dia_pkg::REG_TRIGGER_LVL: trig_lvl_ff    <= csr_wdata[14:0];
            dia_pkg::REG_MENU_FIRST:  menu_first_ff  <= csr_wdata[15:0];
            dia_pkg::REG_MENU_PERIOD: menu_period_ff <= csr_wdata[15:0];
            dia_pkg::REG_GAME_FIRST:  game_first_ff  <= csr_wdata[15:0];
            dia_pkg::REG_GAME_PERIOD: game_period_ff <= csr_wdata[15:0];
            dia_pkg::REG_POLICY_GAME: policy_game_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_ff.command    <= req_ch.command;
         in_ff.now_ms     <= req_ch.now_ms;
         in_ff.dir_code   <= req_ch.dir_code;
         in_ff.from_dpad  <= req_ch.from_dpad;
         in_ff.pressed    <= req_ch.pressed;
         in_ff.axis_sel   <= req_ch.axis_sel;
         in_ff.axis_value <= req_ch.axis_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
         stx_ff       <= dia_pkg::STK_CENTER;
         sty_ff       <= dia_pkg::STK_CENTER;
         tl_on_ff     <= 1'b0;
         tr_on_ff     <= 1'b0;
         stamp_ff     <= '0;
         seen_ff      <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
         held_ff      <= held_in;
         stx_ff       <= stx_in;
         sty_ff       <= sty_in;
         tl_on_ff     <= tl_on_in;
         tr_on_ff     <= tr_on_in;
         stamp_ff     <= stamp_in;
         seen_ff      <= seen_in;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff <= act_in;
      end
   end

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("event port stalled with room in the pipeline");

   a_reset_clears_masks: assert property (@(posedge clock)
      reset |=> (held_ff == '0) && !in_valid_ff && !rsp_valid_ff)
      else $error("held masks or pipeline not cleared by reset");

   a_button_restarts_timer: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ff.command == dia_pkg::CMD_BUTTON) && (act_in != dia_pkg::ACT_NONE))
      |=> (stamp_ff == $past(now_t)) && !seen_ff)
      else $error("button press did not restart repeat timer");

   a_hold_rotate_from_trigger: assert property (@(posedge clock) disable iff (reset)
      (advance && ((act_in == dia_pkg::ACT_HOLD) || (act_in == dia_pkg::ACT_ROTATE)))
      |-> (in_ff.command == dia_pkg::CMD_TRIGGER))
      else $error("hold or rotate emitted by a non-trigger event");

endmodule

`default_nettype wire

[dv/direction_input_autorepeat_checker.sv]
// ----------------------------------------------------------------------------
// direction_input_autorepeat_checker
// Watches the event, action and register ports of the auto-repeat block,
// keeps its own copy of the held masks, stick and trigger states, repeat
// timer and registers, predicts one action per event and compares each
// action word with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module direction_input_autorepeat_checker (
   input  logic                           clock,
   input  logic                           reset,
   dia_req_if                             req_ch,
   dia_rsp_if                             rsp_ch,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_index,
   input  logic [dia_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [14:0] press_dz, release_dz, trig_lvl;
   logic [15:0] menu_first, menu_period, game_first, game_period;
   logic        policy_game;

   logic [2:0]  held [4];
   logic [1:0]  stk_x, stk_y;
   logic        trig_left_on, trig_right_on;
   logic [31:0] repeat_stamp;
   logic        repeat_seen;

   dia_pkg::action_type expected_actions [$];
   int                  errors = 0;

   function automatic void clear_model();
      press_dz      = 15'd16000;
      release_dz    = 15'd8000;
      trig_lvl      = 15'd8000;
      menu_first    = 16'd300;
      menu_period   = 16'd100;
      game_first    = 16'd170;
      game_period   = 16'd50;
      policy_game   = 1'b0;
      for (int i = 0; i < 4; i++) held[i] = 3'd0;
      stk_x         = dia_pkg::STK_CENTER;
      stk_y         = dia_pkg::STK_CENTER;
      trig_left_on  = 1'b0;
      trig_right_on = 1'b0;
      repeat_stamp  = '0;
      repeat_seen   = 1'b0;
   endfunction

   function automatic void write_setting(logic [2:0] idx,
                                         logic [dia_pkg::CSR_DATA_W-1:0] val);
      case (dia_pkg::reg_index_type'(idx))
         dia_pkg::REG_PRESS_DZ:    press_dz    = val[14:0];
         dia_pkg::REG_RELEASE_DZ:  release_dz  = val[14:0];
         dia_pkg::REG_TRIGGER_LVL: trig_lvl    = val[14:0];
         dia_pkg::REG_MENU_FIRST:  menu_first  = val[15:0];
         dia_pkg::REG_MENU_PERIOD: menu_period = val[15:0];
         dia_pkg::REG_GAME_FIRST:  game_first  = val[15:0];
         dia_pkg::REG_GAME_PERIOD: game_period = val[15:0];
         dia_pkg::REG_POLICY_GAME: policy_game = val[0];
         default: ;
      endcase
   endfunction

   function automatic dia_pkg::action_type hold_source(logic [1:0] dir, logic [2:0] src,
                                                       bit down, logic [31:0] t);
      logic [2:0] was, now_held;
      was = held[dir];
      now_held = down ? (was | src) : (was & ~src);
      held[dir] = now_held;
      if (was == 3'd0 && now_held != 3'd0) begin
         repeat_stamp = t;
         repeat_seen  = 1'b0;
         return dia_pkg::action_type'({1'b0, dir} + 3'd1);
      end
      return dia_pkg::ACT_NONE;
   endfunction

   function automatic dia_pkg::action_type stick_move(bit vertical, logic signed [15:0] v,
                                                      logic [31:0] t);
      int                  vi, pz, rz;
      logic [1:0]          old, nxt, neg_dir, pos_dir;
      dia_pkg::action_type act;
      vi = int'(v);
      pz = int'(press_dz);
      rz = int'(release_dz);
      old = vertical ? stk_y : stk_x;
      if (old != dia_pkg::STK_NEG && old != dia_pkg::STK_POS) old = dia_pkg::STK_CENTER;
      neg_dir = vertical ? dia_pkg::DIR_UP : dia_pkg::DIR_LEFT;
      pos_dir = vertical ? dia_pkg::DIR_DOWN : dia_pkg::DIR_RIGHT;
      nxt = old;
      if (old == dia_pkg::STK_CENTER) begin
         if (vi <= -pz) nxt = dia_pkg::STK_NEG;
         else if (vi >= pz) nxt = dia_pkg::STK_POS;
      end else begin
         if (vi > -rz && vi < rz) nxt = dia_pkg::STK_CENTER;
         else if (old == dia_pkg::STK_NEG && vi >= pz) nxt = dia_pkg::STK_POS;
         else if (old == dia_pkg::STK_POS && vi <= -pz) nxt = dia_pkg::STK_NEG;
      end
      if (nxt == old) return dia_pkg::ACT_NONE;
      if (old == dia_pkg::STK_NEG)
         void'(hold_source(neg_dir, dia_pkg::SRC_STICK, 1'b0, t));
      else if (old == dia_pkg::STK_POS)
         void'(hold_source(pos_dir, dia_pkg::SRC_STICK, 1'b0, t));
      if (vertical) stk_y = nxt;
      else stk_x = nxt;
      act = dia_pkg::ACT_NONE;
      if (nxt == dia_pkg::STK_NEG)
         act = hold_source(neg_dir, dia_pkg::SRC_STICK, 1'b1, t);
      else if (nxt == dia_pkg::STK_POS)
         act = hold_source(pos_dir, dia_pkg::SRC_STICK, 1'b1, t);
      return act;
   endfunction

   function automatic dia_pkg::action_type repeat_due(logic [31:0] t);
      logic [1:0]  dir;
      logic [15:0] delay;
      logic [31:0] elapsed;
      if (held[dia_pkg::DIR_DOWN] != 3'd0) dir = dia_pkg::DIR_DOWN;
      else if (held[dia_pkg::DIR_LEFT] != 3'd0) dir = dia_pkg::DIR_LEFT;
      else if (held[dia_pkg::DIR_RIGHT] != 3'd0) dir = dia_pkg::DIR_RIGHT;
      else if (held[dia_pkg::DIR_UP] != 3'd0) dir = dia_pkg::DIR_UP;
      else return dia_pkg::ACT_NONE;
      if (policy_game && dir == dia_pkg::DIR_UP) return dia_pkg::ACT_NONE;
      if (policy_game) delay = repeat_seen ? game_period : game_first;
      else delay = repeat_seen ? menu_period : menu_first;
      elapsed = t - repeat_stamp;
      if (elapsed >= {16'd0, delay}) begin
         repeat_stamp = t;
         repeat_seen  = 1'b1;
         return dia_pkg::action_type'({1'b0, dir} + 3'd1);
      end
      return dia_pkg::ACT_NONE;
   endfunction

   function automatic dia_pkg::action_type next_action(dia_pkg::req_word_type w);
      int                  vi, lvl;
      bit                  down;
      dia_pkg::action_type act;
      act = dia_pkg::ACT_NONE;
      case (dia_pkg::cmd_type'(w.command))
         dia_pkg::CMD_TICK:   act = repeat_due(w.now_ms);
         dia_pkg::CMD_BUTTON: act = hold_source(w.dir_code,
                                                w.from_dpad ? dia_pkg::SRC_DPAD :
                                                              dia_pkg::SRC_KEY,
                                                w.pressed, w.now_ms);
         dia_pkg::CMD_STICK:  act = stick_move(w.axis_sel, w.axis_value, w.now_ms);
         default: begin
            vi = int'(w.axis_value);
            lvl = int'(trig_lvl);
            down = (vi > lvl);
            if (w.axis_sel) begin
               if (down != trig_right_on) begin
                  trig_right_on = down;
                  if (down) act = dia_pkg::ACT_ROTATE;
               end
            end else begin
               if (down != trig_left_on) begin
                  trig_left_on = down;
                  if (down) act = dia_pkg::ACT_HOLD;
               end
            end
         end
      endcase
      return act;
   endfunction

   always @(posedge clock) begin : monitor
      dia_pkg::req_word_type w;
      dia_pkg::action_type   want;
      if (reset) begin
         clear_model();
         expected_actions.delete();
      end else begin
         if (csr_we) write_setting(csr_index, csr_wdata);
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            w.command    = req_ch.command;
            w.now_ms     = req_ch.now_ms;
            w.dir_code   = req_ch.dir_code;
            w.from_dpad  = req_ch.from_dpad;
            w.pressed    = req_ch.pressed;
            w.axis_sel   = req_ch.axis_sel;
            w.axis_value = req_ch.axis_value;
            expected_actions.push_back(next_action(w));
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_actions.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: action word %0d with no event waiting", $realtime,
                           rsp_ch.action_code);
            end else begin
               want = expected_actions.pop_front();
               if (rsp_ch.action_code !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: action_code mismatch, expected %0d got %0d", $realtime,
                              want, rsp_ch.action_code);
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_actions.size();
   end

endmodule

`default_nettype wire

[dv/direction_input_autorepeat_test.sv]
// ----------------------------------------------------------------------------
// direction_input_autorepeat_test
// Stimulus for the direction auto-repeat block: a directed pass over the
// button, stick, trigger and repeat corner cases, then register phases from
// all-zero to all-max with random event bursts, receiver stalls and one long
// back-pressure stretch. The checker beside the block scores every action.
// ----------------------------------------------------------------------------
`default_nettype none

module direction_input_autorepeat_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 300000;
   localparam int HOLD_CYCLES  = 80;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           csr_we    = 1'b0;
   logic [2:0]                     csr_index = '0;
   logic [dia_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending_count;
   int hold_requests = 0;
   int cycle_count   = 0;

   logic [14:0] press_dz_cfg   = 15'd16000;
   logic [14:0] release_dz_cfg = 15'd8000;
   logic [14:0] trig_lvl_cfg   = 15'd8000;
   logic [15:0] menu_first_cfg = 16'd300;
   logic [15:0] game_first_cfg = 16'd170;
   logic        policy_cfg     = 1'b0;
   logic [31:0] ms_now         = 32'd500;

   dia_req_if req_ch ();
   dia_rsp_if rsp_ch ();

   direction_input_autorepeat #(.TIME_BITS(32)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   direction_input_autorepeat_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (fail_count),
      .pending_count  (pending_count)
   );

   always #6 clock = ~clock;

   task automatic send_word(dia_pkg::req_word_type w);
      req_ch.valid      <= 1'b1;
      req_ch.command    <= w.command;
      req_ch.now_ms     <= w.now_ms;
      req_ch.dir_code   <= w.dir_code;
      req_ch.from_dpad  <= w.from_dpad;
      req_ch.pressed    <= w.pressed;
      req_ch.axis_sel   <= w.axis_sel;
      req_ch.axis_value <= w.axis_value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(dia_pkg::reg_index_type idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         dia_pkg::REG_PRESS_DZ:    press_dz_cfg   = val[14:0];
         dia_pkg::REG_RELEASE_DZ:  release_dz_cfg = val[14:0];
         dia_pkg::REG_TRIGGER_LVL: trig_lvl_cfg   = val[14:0];
         dia_pkg::REG_MENU_FIRST:  menu_first_cfg = val;
         dia_pkg::REG_GAME_FIRST:  game_first_cfg = val;
         dia_pkg::REG_POLICY_GAME: policy_cfg     = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(int kind);
      logic [15:0] pz, rz, tl, mf, mp, gf, gp, pol;
      pz = 16'd16000; rz = 16'd8000; tl = 16'd8000;
      mf = 16'd300; mp = 16'd100; gf = 16'd170; gp = 16'd50; pol = 16'd0;
      case (kind)
         1: begin
            pz = 16'($urandom_range(4000, 30000));
            rz = 16'($urandom_range(1000, int'(pz)));
            tl = 16'($urandom_range(0, 32767));
            mf = 16'($urandom_range(50, 400));
            mp = 16'($urandom_range(10, 150));
            gf = 16'($urandom_range(50, 400));
            gp = 16'($urandom_range(10, 150));
            pol = 16'd1;
         end
         2: begin
            pz = '0; rz = '0; tl = '0; mf = '0; mp = '0; gf = '0; gp = '0; pol = '0;
         end
         3: begin
            pz = 16'h7FFF; rz = 16'h7FFF; tl = 16'h7FFF;
            mf = 16'hFFFF; mp = 16'hFFFF; gf = 16'hFFFF; gp = 16'hFFFF; pol = 16'd1;
         end
         4: begin
            pz = 16'd1500; rz = 16'd24000;
            tl = 16'($urandom_range(0, 32767));
            mf = 16'($urandom_range(0, 200));
            mp = 16'($urandom_range(0, 80));
            gf = 16'($urandom_range(0, 200));
            gp = 16'($urandom_range(0, 80));
            pol = 16'($urandom_range(0, 1));
         end
         5: begin
            pz = 16'($urandom_range(0, 32767));
            rz = 16'($urandom_range(0, 32767));
            tl = 16'($urandom_range(0, 32767));
            mf = 16'($urandom_range(0, 65535));
            mp = 16'($urandom_range(0, 65535));
            gf = 16'($urandom_range(0, 65535));
            gp = 16'($urandom_range(0, 65535));
            pol = 16'($urandom_range(0, 1));
         end
         default: ;
      endcase
      write_reg(dia_pkg::REG_PRESS_DZ, pz);
      write_reg(dia_pkg::REG_RELEASE_DZ, rz);
      write_reg(dia_pkg::REG_TRIGGER_LVL, tl);
      write_reg(dia_pkg::REG_MENU_FIRST, mf);
      write_reg(dia_pkg::REG_MENU_PERIOD, mp);
      write_reg(dia_pkg::REG_GAME_FIRST, gf);
      write_reg(dia_pkg::REG_GAME_PERIOD, gp);
      write_reg(dia_pkg::REG_POLICY_GAME, pol);
      csr_we <= 1'b0;
   endtask

   function automatic dia_pkg::req_word_type ev(dia_pkg::cmd_type c, logic [31:0] t,
                                                logic [1:0] d, bit dp, bit pr, bit sel,
                                                int v);
      dia_pkg::req_word_type w;
      w.command    = c;
      w.now_ms     = t;
      w.dir_code   = d;
      w.from_dpad  = dp;
      w.pressed    = pr;
      w.axis_sel   = sel;
      w.axis_value = v[15:0];
      return w;
   endfunction

   function automatic logic signed [15:0] pick_axis();
      int pz, rz, v;
      pz = int'(press_dz_cfg);
      rz = int'(release_dz_cfg);
      case ($urandom_range(0, 11))
         0: v = pz;
         1: v = -pz;
         2: v = pz - 1;
         3: v = 1 - pz;
         4: v = rz;
         5: v = -rz;
         6: v = rz - 1;
         7: v = 1 - rz;
         8: v = 32767;
         9: v = -32768;
         10: v = 0;
         default: v = $urandom_range(0, 65535) - 32768;
      endcase
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] pick_trigger();
      int tl, v;
      tl = int'(trig_lvl_cfg);
      case ($urandom_range(0, 6))
         0: v = tl;
         1: v = tl + 1;
         2: v = 32767;
         3: v = -32768;
         4: v = 0;
         default: v = $urandom_range(0, 65535) - 32768;
      endcase
      return v[15:0];
   endfunction

   function automatic dia_pkg::req_word_type next_event();
      logic [63:0]           r;
      dia_pkg::req_word_type w;
      int                    pick, span;
      r = {$urandom, $urandom};
      w = r[54:0];
      span = int'(policy_cfg ? game_first_cfg : menu_first_cfg);
      pick = $urandom_range(0, 99);
      if (pick < 3) ms_now = $urandom;
      else if (pick < 6) ms_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
      else if (pick < 10) ms_now += $urandom_range(0, 70000);
      else ms_now += $urandom_range(0, (span >> 2) + 3);
      w.now_ms = ms_now;
      pick = $urandom_range(0, 99);
      if (pick < 10) return w;
      if (pick < 45) w.command = dia_pkg::CMD_TICK;
      else if (pick < 68) w.command = dia_pkg::CMD_BUTTON;
      else if (pick < 86) begin
         w.command = dia_pkg::CMD_STICK;
         w.axis_value = pick_axis();
      end else begin
         w.command = dia_pkg::CMD_TRIGGER;
         w.axis_value = pick_trigger();
      end
      return w;
   endfunction

   task automatic random_run(int count, bit gaps);
      int burst_left, g;
      burst_left = $urandom_range(1, 30);
      for (int i = 0; i < count; i++) begin
         if (gaps && burst_left == 0) begin
            g = $urandom_range(0, 6);
            if (g > 0) begin
               req_ch.valid <= 1'b0;
               repeat (g) @(posedge clock);
            end
            burst_left = $urandom_range(1, 30);
         end
         send_word(next_event());
         burst_left--;
      end
   endtask

   task automatic directed_items();
      send_word(ev(dia_pkg::CMD_TICK, 100, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_BUTTON, 1000, dia_pkg::DIR_UP, 1'b0, 1'b1, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_BUTTON, 1001, dia_pkg::DIR_UP, 1'b1, 1'b1, 1'b1, -1));
      send_word(ev(dia_pkg::CMD_TICK, 1299, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_TICK, 1300, dia_pkg::DIR_RIGHT, 1'b1, 1'b1, 1'b1, 32767));
      send_word(ev(dia_pkg::CMD_TICK, 1399, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_TICK, 1400, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_BUTTON, 1410, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_BUTTON, 1420, dia_pkg::DIR_UP, 1'b1, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_STICK, 1500, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, -16000));
      send_word(ev(dia_pkg::CMD_STICK, 1510, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 16000));
      send_word(ev(dia_pkg::CMD_STICK, 1520, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 7999));
      send_word(ev(dia_pkg::CMD_STICK, 1530, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b1, -32768));
      send_word(ev(dia_pkg::CMD_STICK, 1540, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b1, 8000));
      send_word(ev(dia_pkg::CMD_STICK, 1550, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b1, 7999));
      send_word(ev(dia_pkg::CMD_TRIGGER, 1600, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 8000));
      send_word(ev(dia_pkg::CMD_TRIGGER, 1610, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 8001));
      send_word(ev(dia_pkg::CMD_TRIGGER, 1620, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, 32767));
      send_word(ev(dia_pkg::CMD_TRIGGER, 1630, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b0, -32768));
      send_word(ev(dia_pkg::CMD_TRIGGER, 1640, dia_pkg::DIR_UP, 1'b0, 1'b0, 1'b1, 32767));
      send_word(ev(dia_pkg::CMD_BUTTON, 32'hFFFF_FF00, dia_pkg::DIR_DOWN,
                   1'b1, 1'b1, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_BUTTON, 32'hFFFF_FF10, dia_pkg::DIR_LEFT,
                   1'b0, 1'b1, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_TICK, 32'h0000_002C, dia_pkg::DIR_UP,
                   1'b0, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_BUTTON, 32'h0000_0030, dia_pkg::DIR_DOWN,
                   1'b1, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_TICK, 32'h0000_0090, dia_pkg::DIR_UP,
                   1'b0, 1'b0, 1'b0, 0));
      send_word(ev(dia_pkg::CMD_BUTTON, 32'h0000_00A0, dia_pkg::DIR_LEFT,
                   1'b0, 1'b0, 1'b0, 0));
   endtask

   initial begin : receiver
      int pct, left, served;
      pct = 100;
      left = 0;
      served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served = hold_requests;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (left == 0) begin
               case ($urandom_range(0, 3))
                  0: pct = 100;
                  1: pct = 90;
                  2: pct = 50;
                  default: pct = 20;
               endcase
               left = $urandom_range(20, 200);
            end
            left--;
            rsp_ch.ready <= ($urandom_range(1, 100) <= pct);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int kinds [10];
      kinds = '{1, 2, 3, 4, 5, 0, 5, 3, 4, 1};
      req_ch.valid      <= 1'b0;
      req_ch.command    <= dia_pkg::CMD_TICK;
      req_ch.now_ms     <= '0;
      req_ch.dir_code   <= dia_pkg::DIR_UP;
      req_ch.from_dpad  <= 1'b0;
      req_ch.pressed    <= 1'b0;
      req_ch.axis_sel   <= 1'b0;
      req_ch.axis_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      drain();
      for (int phase = 0; phase < 10; phase++) begin
         load_settings(kinds[phase]);
         random_run(135, (phase % 3) != 1);
         if (phase == 4) begin
            hold_requests <= hold_requests + 1;
            repeat (12) send_word(next_event());
         end
         drain();
      end
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
sv/dia_pkg.sv
sv/dia_req_if.sv
sv/dia_rsp_if.sv
sv/direction_input_autorepeat.sv
dv/direction_input_autorepeat_checker.sv
dv/direction_input_autorepeat_test.sv
